// ===== design/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, codes and helpers for the ring leader election node.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int UID_W   = 32;
  localparam int NODE_W  = 10;
  localparam int HOPS_W  = 12;
  localparam int PHASE_W = 4;

  localparam logic [HOPS_W-1:0]  HOPS_TOP  = 12'd2048;
  localparam logic [PHASE_W-1:0] PHASE_TOP = 4'd15;

  // input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MSG   = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // configuration register indexes
  localparam logic CFG_OWN_UID  = 1'b0;
  localparam logic CFG_OWN_NODE = 1'b1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              msg_is_declaration;
    logic [UID_W-1:0]  msg_uid;
    logic [NODE_W-1:0] msg_node;
    logic [HOPS_W-1:0] msg_hops;
    logic              from_right;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    logic              to_right;
    logic              out_is_declaration;
    logic [UID_W-1:0]  out_uid;
    logic [NODE_W-1:0] out_node;
    logic [HOPS_W-1:0] out_hops;
    logic              is_leader;
    logic              is_active;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_MSG,
    CMD_END,
    CMD_NOP
  } cmd_kind_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic              is_decl;
    logic [UID_W-1:0]  uid;
    logic [NODE_W-1:0] node;
    logic [HOPS_W-1:0] hops;
    logic [HOPS_W-1:0] hops_dec;
    logic              right;
    logic              uid_gt;
    logic              uid_eq;
    logic              hops_gt1;
    logic              hops_eq1;
    logic              hops_zero;
  } cmd_t;

  // 2^e, saturating at the top hop count
  function automatic logic [HOPS_W-1:0] pow_hops(input logic [PHASE_W:0] e);
    pow_hops = (e >= 5'd11) ? HOPS_TOP : (12'd1 << e);
  endfunction

endpackage

// ===== design/rle_in_if.sv =====
// ----------------------------------------------------------------------------
// rle_in_if
// Input request channel: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface rle_in_if;
  logic             valid;
  logic             ready;
  rle_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rle_out_if.sv =====
// ----------------------------------------------------------------------------
// rle_out_if
// Result request channel: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface rle_out_if;
  logic             valid;
  logic             ready;
  rle_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rle_front.sv =====
// ----------------------------------------------------------------------------
// rle_front
// Accepts input items and classifies them; does the wide uid compares.
// ----------------------------------------------------------------------------
module rle_front (
  rle_in_if.sink                        in_ch,
  input  logic [rle_pkg::UID_W-1:0]     own_uid,
  output logic                          cmd_valid,
  output rle_pkg::cmd_t                 cmd,
  input  logic                          cmd_ready
);
  import rle_pkg::*;

  // pass the handshake straight to the queue
  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  // decode opcode and precompute comparisons
  always_comb begin
    case (in_ch.payload.opcode)
      OP_START: cmd.kind = CMD_START;
      OP_MSG:   cmd.kind = CMD_MSG;
      OP_END:   cmd.kind = CMD_END;
      default:  cmd.kind = CMD_NOP;
    endcase
    cmd.is_decl   = in_ch.payload.msg_is_declaration;
    cmd.uid       = in_ch.payload.msg_uid;
    cmd.node      = in_ch.payload.msg_node;
    cmd.hops      = in_ch.payload.msg_hops;
    cmd.hops_dec  = in_ch.payload.msg_hops - 12'd1;
    cmd.right     = in_ch.payload.from_right;
    cmd.uid_gt    = in_ch.payload.msg_uid > own_uid;
    cmd.uid_eq    = in_ch.payload.msg_uid == own_uid;
    cmd.hops_gt1  = in_ch.payload.msg_hops > 12'd1;
    cmd.hops_eq1  = in_ch.payload.msg_hops == 12'd1;
    cmd.hops_zero = in_ch.payload.msg_hops == 12'd0;
  end
endmodule

// ===== design/rle_queue.sv =====
// ----------------------------------------------------------------------------
// rle_queue
// Short FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module rle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  rle_pkg::cmd_t wr_data,
  output logic          wr_ready,
  output logic          rd_valid,
  output rle_pkg::cmd_t rd_data,
  input  logic          rd_ready
);
  import rle_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = count != CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== design/rle_back.sv =====
// ----------------------------------------------------------------------------
// rle_back
// Carries out classified requests against the election state and drives
// the result channel through an output register and a second-result hold.
// ----------------------------------------------------------------------------
module rle_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rle_pkg::UID_W-1:0]  own_uid,
  input  logic [rle_pkg::NODE_W-1:0] own_node,
  input  logic                       cmd_valid,
  input  rle_pkg::cmd_t              cmd,
  output logic                       cmd_ready,
  rle_out_if.source                  out_ch
);
  import rle_pkg::*;

  // election state
  logic [PHASE_W-1:0] phase,          phase_next;
  logic               phase_changed,  phase_changed_next;
  logic               left_returned,  left_returned_next;
  logic               right_returned, right_returned_next;
  logic               leader_flag,    leader_flag_next;
  logic               seen_leader,    seen_leader_next;
  logic               node_active,    node_active_next;
  logic               skip_round,     skip_round_next;
  logic [UID_W-1:0]   decl_uid,       decl_uid_next;
  logic [NODE_W-1:0]  decl_node,      decl_node_next;
  logic [HOPS_W-1:0]  decl_hops,      decl_hops_next;

  // result staging
  logic    out_valid;
  result_t out_data;
  logic    pend_valid;
  result_t pend_data;
  result_t res0;
  result_t res1;
  logic    two;
  logic    out_free;
  logic    exec;

  assign out_free     = !out_valid || out_ch.ready;
  assign cmd_ready    = !pend_valid && out_free;
  assign exec         = cmd_valid && cmd_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_data;

  // execute one request
  always_comb begin
    phase_next          = phase;
    phase_changed_next  = phase_changed;
    left_returned_next  = left_returned;
    right_returned_next = right_returned;
    leader_flag_next    = leader_flag;
    seen_leader_next    = seen_leader;
    node_active_next    = node_active;
    skip_round_next     = skip_round;
    decl_uid_next       = decl_uid;
    decl_node_next      = decl_node;
    decl_hops_next      = decl_hops;
    res0 = '0;
    res1 = '0;
    two  = 1'b0;

    case (cmd.kind)
      CMD_START: begin
        if (node_active && (leader_flag || seen_leader)) begin
          node_active_next        = 1'b0;
          two                     = 1'b1;
          res0.send_valid         = 1'b1;
          res0.out_is_declaration = 1'b1;
          res0.out_uid            = decl_uid;
          res0.out_node           = decl_node;
          res0.out_hops           = decl_hops;
          res1                    = res0;
          res1.to_right           = 1'b1;
        end else if (node_active && phase_changed) begin
          phase_changed_next  = 1'b0;
          left_returned_next  = 1'b0;
          right_returned_next = 1'b0;
          two                 = 1'b1;
          res0.send_valid     = 1'b1;
          res0.out_uid        = own_uid;
          res0.out_node       = own_node;
          res0.out_hops       = pow_hops({1'b0, phase});
          res1                = res0;
          res1.to_right       = 1'b1;
        end
      end
      CMD_MSG: begin
        if (node_active && !skip_round) begin
          if (cmd.is_decl) begin
            decl_uid_next    = cmd.uid;
            decl_node_next   = cmd.node;
            decl_hops_next   = cmd.hops;
            seen_leader_next = 1'b1;
            skip_round_next  = 1'b1;
          end else if (cmd.uid_gt && cmd.hops_gt1) begin
            // pass the probe on
            res0.send_valid = 1'b1;
            res0.to_right   = !cmd.right;
            res0.out_uid    = cmd.uid;
            res0.out_node   = own_node;
            res0.out_hops   = cmd.hops_dec;
          end else if (cmd.uid_gt && cmd.hops_eq1) begin
            // turn the probe back as a reply
            res0.send_valid = 1'b1;
            res0.to_right   = cmd.right;
            res0.out_uid    = cmd.uid;
            res0.out_node   = own_node;
          end else if (cmd.uid_eq) begin
            if (!cmd.hops_zero) begin
              leader_flag_next = 1'b1;
              decl_uid_next    = own_uid;
              decl_node_next   = own_node;
              decl_hops_next   = pow_hops({1'b0, phase} + 5'd1);
            end else if (cmd.right) begin
              right_returned_next = 1'b1;
            end else begin
              left_returned_next = 1'b1;
            end
          end else if (cmd.hops_zero) begin
            // relay a reply of another node
            res0.send_valid = 1'b1;
            res0.to_right   = !cmd.right;
            res0.out_uid    = cmd.uid;
            res0.out_node   = own_node;
          end
        end
      end
      CMD_END: begin
        if (node_active && !skip_round && left_returned && right_returned) begin
          if (phase != PHASE_TOP) begin
            phase_next = phase + 1'b1;
          end
          phase_changed_next = 1'b1;
        end
        skip_round_next = 1'b0;
      end
      default: begin
      end
    endcase

    res0.is_leader = leader_flag_next;
    res0.is_active = node_active_next;
    res0.last      = !two;
    res1.is_leader = leader_flag_next;
    res1.is_active = node_active_next;
    res1.last      = 1'b1;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      phase_changed  <= 1'b1;
      left_returned  <= 1'b0;
      right_returned <= 1'b0;
      leader_flag    <= 1'b0;
      seen_leader    <= 1'b0;
      node_active    <= 1'b1;
      skip_round     <= 1'b0;
      decl_uid       <= '0;
      decl_node      <= '0;
      decl_hops      <= '0;
    end else if (exec) begin
      phase          <= phase_next;
      phase_changed  <= phase_changed_next;
      left_returned  <= left_returned_next;
      right_returned <= right_returned_next;
      leader_flag    <= leader_flag_next;
      seen_leader    <= seen_leader_next;
      node_active    <= node_active_next;
      skip_round     <= skip_round_next;
      decl_uid       <= decl_uid_next;
      decl_node      <= decl_node_next;
      decl_hops      <= decl_hops_next;
    end
  end

  // output register and second-result hold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= cmd_valid;
        pend_valid <= cmd_valid && two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_data <= pend_data;
      end else if (cmd_valid) begin
        out_data  <= res0;
        pend_data <= res1;
      end
    end
  end
endmodule

// ===== design/ring_leader_election_node_top.sv =====
// ----------------------------------------------------------------------------
// ring_leader_election_node_top
// One node of a bidirectional ring running Hirschberg-Sinclair election.
//
//   channel  dir  handshake         carries
//   in_ch    in   valid/ready       opcode and received message
//   out_ch   out  valid/ready       one send or status result
//   cfg      in   cfg_we only       own_uid (index 0), own_node (index 1)
//
// Each result passes through the back side's output register; a round
// start that sends gives two results, the second held until the first is
// taken, and every other item one. A two-entry queue lets input be taken while results stall.
// Reset is synchronous and clears all control and election state; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_leader_election_node_top (
  input  logic                       clk,
  input  logic                       rst,
  rle_in_if.sink                     in_ch,
  rle_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [rle_pkg::UID_W-1:0]  cfg_data
);
  import rle_pkg::*;

  logic [UID_W-1:0]  own_uid;
  logic [NODE_W-1:0] own_node;
  logic              f_valid;
  cmd_t              f_cmd;
  logic              f_ready;
  logic              q_valid;
  cmd_t              q_cmd;
  logic              q_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_uid  <= '0;
      own_node <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_UID:  own_uid  <= cfg_data;
        CFG_OWN_NODE: own_node <= cfg_data[NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify
  rle_front u_front (
    .in_ch     (in_ch),
    .own_uid   (own_uid),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  // queue between front and back
  rle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_data  (f_cmd),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_data  (q_cmd),
    .rd_ready (q_ready)
  );

  // back: election state and results
  rle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .own_uid   (own_uid),
    .own_node  (own_node),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .out_ch    (out_ch)
  );
endmodule

// ===== tb/tb_ring_leader_election_node_top.sv =====
// ----------------------------------------------------------------------------
// tb_ring_leader_election_node_top
// Self-checking bench for one ring leader election node. Requests are
// queued by a stimulus process and fed by a clocked driver. A built-in
// election predictor computes every send and status result. A clocked
// monitor compares the results in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ring_leader_election_node_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rle_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         DRAIN_WAIT  = 16;
  localparam int         LONG_HOLD   = 400;
  localparam int         PHASE_ITEMS = 260;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_index;
  logic [UID_W-1:0] cfg_data;

  rle_in_if  in_ch();
  rle_out_if out_ch();

  ring_leader_election_node_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // election state of the node as the predictor sees it
  logic [UID_W-1:0]   node_uid = '0;
  logic [NODE_W-1:0]  node_idx = '0;
  logic [PHASE_W-1:0] el_phase = '0;
  bit phase_moved  = 1'b1;
  bit left_back    = 1'b0;
  bit right_back   = 1'b0;
  bit leader_now   = 1'b0;
  bit leader_heard = 1'b0;
  bit active_now   = 1'b1;
  bit ignore_round = 1'b0;
  logic [UID_W-1:0]  stored_uid  = '0;
  logic [NODE_W-1:0] stored_node = '0;
  logic [HOPS_W-1:0] stored_hops = '0;

  in_item_t pending_requests[$];
  result_t  expected_results[$];

  // run control and statistics
  bit idle_enabled = 1'b1;
  int hold_asked = 0;
  int hold_given = 0;
  int send_gap = 0;
  int sink_stall = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int sends_seen = 0;
  int decls_seen = 0;
  int settings_used = 0;
  int top_phase = 0;

  // hop count 2^e, saturating at the top value
  function automatic logic [HOPS_W-1:0] hop_count(input int e);
    if (e >= 11) return HOPS_TOP;
    return HOPS_W'(1 << e);
  endfunction

  function automatic void add_expected(bit sv, bit rt, bit dc, logic [UID_W-1:0] u,
                                       logic [NODE_W-1:0] n, logic [HOPS_W-1:0] h,
                                       bit lst);
    result_t r;
    r.send_valid         = sv;
    r.to_right           = rt;
    r.out_is_declaration = dc;
    r.out_uid            = u;
    r.out_node           = n;
    r.out_hops           = h;
    r.is_leader          = leader_now;
    r.is_active          = active_now;
    r.last               = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void add_status();
    add_expected(1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b1);
  endfunction

  // advance the election state by one accepted request
  function automatic void predict_node_step(in_item_t it);
    logic [HOPS_W-1:0] h;
    case (it.opcode)
      OP_START: begin
        if (!active_now) begin
          add_status();
        end else if (leader_now || leader_heard) begin
          // announce the known leader on both sides and retire
          active_now = 1'b0;
          add_expected(1'b1, 1'b0, 1'b1, stored_uid, stored_node, stored_hops, 1'b0);
          add_expected(1'b1, 1'b1, 1'b1, stored_uid, stored_node, stored_hops, 1'b1);
        end else if (!phase_moved) begin
          add_status();
        end else begin
          phase_moved = 1'b0;
          left_back   = 1'b0;
          right_back  = 1'b0;
          h = hop_count(el_phase);
          add_expected(1'b1, 1'b0, 1'b0, node_uid, node_idx, h, 1'b0);
          add_expected(1'b1, 1'b1, 1'b0, node_uid, node_idx, h, 1'b1);
        end
      end
      OP_MSG: begin
        if (!active_now || ignore_round) begin
          add_status();
        end else if (it.msg_is_declaration) begin
          stored_uid   = it.msg_uid;
          stored_node  = it.msg_node;
          stored_hops  = it.msg_hops;
          leader_heard = 1'b1;
          ignore_round = 1'b1;
          add_status();
        end else if (node_uid < it.msg_uid && it.msg_hops > 1) begin
          // pass on, away from the arrival side
          add_expected(1'b1, !it.from_right, 1'b0, it.msg_uid, node_idx,
                       it.msg_hops - 1'b1, 1'b1);
        end else if (node_uid < it.msg_uid && it.msg_hops == 1) begin
          // turn back as a reply
          add_expected(1'b1, it.from_right, 1'b0, it.msg_uid, node_idx, '0, 1'b1);
        end else if (it.msg_uid == node_uid) begin
          if (it.msg_hops != 0) begin
            leader_now  = 1'b1;
            stored_uid  = node_uid;
            stored_node = node_idx;
            stored_hops = hop_count(int'(el_phase) + 1);
          end else if (it.from_right) begin
            right_back = 1'b1;
          end else begin
            left_back = 1'b1;
          end
          add_status();
        end else if (it.msg_hops == 0) begin
          // relay a reply owned by another node
          add_expected(1'b1, !it.from_right, 1'b0, it.msg_uid, node_idx, '0, 1'b1);
        end else begin
          add_status();
        end
      end
      OP_END: begin
        if (active_now && !ignore_round && left_back && right_back) begin
          if (el_phase < PHASE_TOP) el_phase = el_phase + 1'b1;
          phase_moved = 1'b1;
        end
        ignore_round = 1'b0;
        if (int'(el_phase) > top_phase) top_phase = int'(el_phase);
        add_status();
      end
      default: add_status();
    endcase
  endfunction

  function automatic string describe(result_t r);
    return $sformatf({"send %0b right %0b decl %0b uid %08h node %0d hops %0d ",
                      "leader %0b active %0b last %0b"},
                     r.send_valid, r.to_right, r.out_is_declaration, r.out_uid, r.out_node,
                     r.out_hops, r.is_leader, r.is_active, r.last);
  endfunction

  // compare one result with the oldest expectation
  function automatic void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("result %0d not expected: %s", results_checked,
                                         describe(got));
    end else begin
      want = expected_results.pop_front();
      if (got.send_valid !== want.send_valid || got.to_right !== want.to_right ||
          got.out_is_declaration !== want.out_is_declaration ||
          got.out_uid !== want.out_uid || got.out_node !== want.out_node ||
          got.out_hops !== want.out_hops || got.is_leader !== want.is_leader ||
          got.is_active !== want.is_active || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d mismatch", results_checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    end
    results_checked++;
    if (got.send_valid === 1'b1) sends_seen++;
    if (got.send_valid === 1'b1 && got.out_is_declaration === 1'b1) decls_seen++;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  always @(posedge clk) begin : feed_requests
    bit offer;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_node_step(in_ch.payload);
        items_accepted++;
        offer = 1'b0;
        send_gap = pick_gap();
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() != 0) begin
          in_ch.payload <= pending_requests.pop_front();
          offer = 1'b1;
        end
      end
      in_ch.valid <= offer;
    end
  end

  // result monitor with random and long back-pressure
  always @(posedge clk) begin : take_results
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.payload);
        sink_stall = pick_gap();
      end
      if (hold_asked > hold_given) begin
        hold_given++;
        sink_stall = LONG_HOLD;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** ring_leader_election_node_top: FAILED **");
      $finish;
    end
  end

  // ---- stimulus helpers ----

  function automatic in_item_t req(logic [1:0] op, bit decl, logic [UID_W-1:0] uid,
                                   logic [NODE_W-1:0] node, logic [HOPS_W-1:0] hops,
                                   bit right);
    in_item_t it;
    it.opcode             = op;
    it.msg_is_declaration = decl;
    it.msg_uid            = uid;
    it.msg_node           = node;
    it.msg_hops           = hops;
    it.from_right         = right;
    return it;
  endfunction

  function automatic logic [HOPS_W-1:0] rand_hops();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return HOPS_W'(1);
      2: return HOPS_TOP;
      3: return HOPS_W'(2);
      default: return HOPS_W'($urandom_range(0, 2048));
    endcase
  endfunction

  // round marker with random don't-care fields
  function automatic in_item_t round_mark(logic [1:0] op);
    return req(op, 1'($urandom_range(0, 1)), $urandom, NODE_W'($urandom_range(0, 1023)),
               rand_hops(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic in_item_t own_reply(bit right);
    return req(OP_MSG, 1'b0, node_uid, NODE_W'($urandom_range(0, 1023)), '0, right);
  endfunction

  // probe or reply from another node: never our own uid with hops left
  function automatic in_item_t foreign_probe();
    logic [UID_W-1:0]  u;
    logic [HOPS_W-1:0] h;
    int r;
    r = $urandom_range(0, 9);
    h = rand_hops();
    if (r < 5 && node_uid != '1) begin
      u = (r == 0) ? '1 : $urandom_range(32'hFFFF_FFFF, node_uid + 1);
    end else if (r < 8 && node_uid != '0) begin
      u = (r == 5) ? '0 : $urandom_range(node_uid - 1, 0);
    end else begin
      u = $urandom;
      if (u == node_uid) h = '0;
    end
    return req(OP_MSG, 1'b0, u, NODE_W'($urandom_range(0, 1023)), h,
               1'($urandom_range(0, 1)));
  endfunction

  function automatic in_item_t rand_declaration();
    logic [UID_W-1:0]  u;
    logic [NODE_W-1:0] n;
    case ($urandom_range(0, 3))
      0: u = '0;
      1: u = '1;
      default: u = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: n = '0;
      1: n = '1;
      default: n = NODE_W'($urandom_range(0, 1023));
    endcase
    return req(OP_MSG, 1'b1, u, n, rand_hops(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void offer_request(in_item_t it);
    pending_requests.push_back(it);
    items_queued++;
  endfunction

  // one election round: start, shuffled traffic with our replies, end
  function automatic void queue_round();
    in_item_t body[$];
    int n;
    if ($urandom_range(0, 19) == 0)
      offer_request(round_mark($urandom_range(0, 1) ? OP_UNUSED : OP_END));
    offer_request(round_mark(OP_START));
    n = $urandom_range(0, 5);
    repeat (n) body.push_back(foreign_probe());
    if ($urandom_range(0, 99) < 85) body.insert($urandom_range(0, body.size()), own_reply(1'b0));
    if ($urandom_range(0, 99) < 85) body.insert($urandom_range(0, body.size()), own_reply(1'b1));
    if ($urandom_range(0, 9) == 0)
      body.insert($urandom_range(0, body.size()), round_mark(OP_START));
    foreach (body[i]) offer_request(body[i]);
    offer_request(round_mark(OP_END));
  endfunction

  // round after a leader is known: no start, declarations mixed in
  function automatic void queue_late_round();
    int n, r;
    n = $urandom_range(1, 6);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) offer_request(foreign_probe());
      else if (r < 65) offer_request(own_reply(1'($urandom_range(0, 1))));
      else if (r < 85) offer_request(rand_declaration());
      else if (r < 90) offer_request(req(OP_MSG, 1'b0, node_uid,
                                         NODE_W'($urandom_range(0, 1023)),
                                         HOPS_W'($urandom_range(1, 2048)),
                                         1'($urandom_range(0, 1))));
      else offer_request(round_mark(OP_UNUSED));
    end
    offer_request(round_mark(OP_END));
  endfunction

  task automatic set_node_config(logic [UID_W-1:0] uid, logic [NODE_W-1:0] node);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_UID;
    cfg_data  <= uid;
    @(posedge clk);
    cfg_index <= CFG_OWN_NODE;
    cfg_data  <= UID_W'(node);
    @(posedge clk);
    cfg_we <= 1'b0;
    node_uid = uid;
    node_idx = node;
    settings_used++;
  endtask

  // sender pause: every queued request taken and every expected result seen
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || items_accepted != items_queued ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---- main sequence ----
  initial begin : run_election
    int k;
    logic [UID_W-1:0] own;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_OWN_UID;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every opcode, probe pass, turn-back, relay and drop, phase steps
    set_node_config(32'h8000_0000, 10'h2AA);
    own = node_uid;
    offer_request(req(OP_UNUSED, 1'b1, '1, '1, HOPS_TOP, 1'b1));
    offer_request(round_mark(OP_START));
    offer_request(round_mark(OP_START));
    offer_request(req(OP_MSG, 1'b0, '1, '0, HOPS_TOP, 1'b0));
    offer_request(req(OP_MSG, 1'b0, own + 1, '1, 12'd1, 1'b1));
    offer_request(req(OP_MSG, 1'b0, 32'hC000_0000, 10'd5, '0, 1'b0));
    offer_request(req(OP_MSG, 1'b0, 32'h0000_1234, '0, 12'd5, 1'b1));
    offer_request(req(OP_MSG, 1'b0, '0, '0, HOPS_TOP, 1'b0));
    offer_request(req(OP_MSG, 1'b0, own - 1, '0, '0, 1'b1));
    offer_request(own_reply(1'b0));
    offer_request(round_mark(OP_END));
    offer_request(round_mark(OP_START));
    offer_request(own_reply(1'b1));
    offer_request(round_mark(OP_END));
    offer_request(round_mark(OP_START));
    offer_request(own_reply(1'b0));
    offer_request(own_reply(1'b1));
    offer_request(round_mark(OP_END));
    offer_request(round_mark(OP_START));
    offer_request(req(OP_UNUSED, 1'b0, '0, '0, '0, 1'b0));
    offer_request(round_mark(OP_END));
    wait_for_drain();

    // random election rounds under several node settings
    for (k = 0; k < 5; k++) begin
      case (k)
        0: set_node_config('0, '0);
        1: set_node_config('1, '1);
        default: set_node_config($urandom, NODE_W'($urandom_range(0, 1023)));
      endcase
      idle_enabled = (k != 2);
      if (k == 1 || k == 3) hold_asked++;
      while (items_queued < 21 + (k + 1) * PHASE_ITEMS) queue_round();
      wait_for_drain();
    end
    idle_enabled = 1'b1;

    // leader known: self-election, declarations, repeated declarations
    set_node_config($urandom, NODE_W'($urandom_range(0, 1023)));
    offer_request(req(OP_MSG, 1'b0, node_uid, '0, HOPS_TOP, 1'b0));
    offer_request(own_reply(1'b0));
    offer_request(own_reply(1'b1));
    offer_request(rand_declaration());
    offer_request(rand_declaration());
    offer_request(round_mark(OP_END));
    repeat (40) queue_late_round();
    wait_for_drain();

    // declaration sent, node retires and ignores the rest
    offer_request(round_mark(OP_END));
    offer_request(req(OP_MSG, 1'b1, '1, '1, HOPS_TOP, 1'b1));
    offer_request(round_mark(OP_END));
    offer_request(round_mark(OP_START));
    offer_request(round_mark(OP_START));
    repeat (30) begin
      if ($urandom_range(0, 1)) offer_request(rand_declaration());
      else offer_request(round_mark(2'($urandom_range(0, 3))));
    end
    wait_for_drain();

    $display("%0d requests, %0d results checked (%0d sends, %0d declarations)",
             items_accepted, results_checked, sends_seen, decls_seen);
    $display("%0d node settings, highest phase %0d, %0d mismatches",
             settings_used, top_phase, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** ring_leader_election_node_top: PASSED **");
    end else begin
      $display("** ring_leader_election_node_top: FAILED **");
    end
    $finish;
  end

endmodule
